@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the fraction accumulator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, disabled in reset
`define FAR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// overlapping implication, disabled in reset
`define FAR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define FAR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/far_pkg.sv @@
// ---------------------------------------------------------------------------
// Fraction accumulator package
// Widths, codes, payload types and controller/datapath interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package far_pkg;

   localparam int IN_WIDTH   = 16;
   localparam int ACC_WIDTH  = 32;
   localparam int DEN_WIDTH  = ACC_WIDTH - 1;
   localparam int PROD_WIDTH = ACC_WIDTH + IN_WIDTH;
   localparam int DIV_STEPS  = PROD_WIDTH;
   localparam int STEP_WIDTH = $clog2(PROD_WIDTH);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [1:0] MUL_SEL_P1  = 2'd0;
   localparam logic [1:0] MUL_SEL_P2  = 2'd1;
   localparam logic [1:0] MUL_SEL_DEN = 2'd2;

   typedef struct packed {
      logic                        clear_first;
      logic signed [IN_WIDTH-1:0]  numerator;
      logic signed [IN_WIDTH-1:0]  denominator;
   } req_type;

   typedef struct packed {
      logic signed [ACC_WIDTH-1:0] sum_numerator;
      logic [DEN_WIDTH-1:0]        sum_denominator;
      logic                        is_whole;
      logic [1:0]                  status;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       add;
      logic       gcd_step;
      logic       scale;
      logic       div_step;
      logic       div_mid;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic gcd_done;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/far_ctrl.sv @@
// ---------------------------------------------------------------------------
// Fraction accumulator controller
// Sequences multiply, add, binary GCD and the two divisions; owns the
// request and response handshakes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module far_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      far_pkg::cmd_type   cmd,
   input  wire far_pkg::stat_type  stat
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MUL_P1  = 4'd1;
   localparam logic [3:0] S_MUL_P2  = 4'd2;
   localparam logic [3:0] S_MUL_DEN = 4'd3;
   localparam logic [3:0] S_ADD     = 4'd4;
   localparam logic [3:0] S_GCD     = 4'd5;
   localparam logic [3:0] S_SCALE   = 4'd6;
   localparam logic [3:0] S_DIV_NUM = 4'd7;
   localparam logic [3:0] S_DIV_MID = 4'd8;
   localparam logic [3:0] S_DIV_DEN = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   localparam logic [far_pkg::STEP_WIDTH-1:0] STEP_LAST =
      far_pkg::STEP_WIDTH'(far_pkg::DIV_STEPS - 1);

   logic [3:0]                      state_ff, state_in;
   logic [far_pkg::STEP_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      cmd.mul_sel = far_pkg::MUL_SEL_P1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_MUL_P1;
            end
         end
         S_MUL_P1: begin
            if (stat.den_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = far_pkg::MUL_SEL_P1;
               state_in    = S_MUL_P2;
            end
         end
         S_MUL_P2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = far_pkg::MUL_SEL_P2;
            state_in    = S_MUL_DEN;
         end
         S_MUL_DEN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = far_pkg::MUL_SEL_DEN;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               state_in = S_SCALE;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            cnt_in    = '0;
            state_in  = S_DIV_NUM;
         end
         S_DIV_NUM: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               state_in = S_DIV_MID;
            end
         end
         S_DIV_MID: begin
            cmd.div_mid = 1'b1;
            cnt_in      = '0;
            state_in    = S_DIV_DEN;
         end
         S_DIV_DEN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FAR_ASSERT_IMP(a_commit_out_free, clock, reset, cmd.commit,
      !rsp_valid_ff || !rsp_stall, "commit while response register occupied")
   `FAR_ASSERT_NXT(a_accept_starts, clock, reset, cmd.accept,
      state_ff == S_MUL_P1 && req_stall, "accepted request did not start")
   `FAR_ASSERT_NXT(a_commit_shows, clock, reset, cmd.commit,
      rsp_valid_ff && state_ff == S_IDLE, "commit did not raise response")

endmodule

`default_nettype wire

@@ rtl/far_dpath.sv @@
// ---------------------------------------------------------------------------
// Fraction accumulator datapath
// Shared multiplier, magnitude add, binary GCD, restoring divider and the
// running sum registers.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module far_dpath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire far_pkg::req_type   req_data,
   output      far_pkg::rsp_type   rsp_data,
   input  wire far_pkg::cmd_type   cmd,
   output      far_pkg::stat_type  stat
);

   localparam int IW = far_pkg::IN_WIDTH;
   localparam int AW = far_pkg::ACC_WIDTH;
   localparam int DW = far_pkg::DEN_WIDTH;
   localparam int PW = far_pkg::PROD_WIDTH;
   localparam int KW = far_pkg::STEP_WIDTH;

   localparam logic [PW-1:0] POS_LIM = (PW'(1) << (AW - 1)) - PW'(1);
   localparam logic [PW-1:0] NEG_LIM = PW'(1) << (AW - 1);

   // running sum
   logic [AW-1:0]  acc_mag_ff, acc_mag_in;
   logic           acc_neg_ff, acc_neg_in;
   logic [DW-1:0]  acc_den_ff, acc_den_in;

   // addend
   logic [IW-1:0]  nraw, draw, nmag, dmag;
   logic [IW-1:0]  nmag_ff, dmag_ff;
   logic           sneg_ff, dzero_ff;

   // products and sum
   logic [AW-1:0]  mul_a;
   logic [IW-1:0]  mul_b;
   logic [PW-1:0]  mul_p;
   logic [PW-1:0]  p1_ff, p2_ff, den_ff, mag_ff;
   logic           rneg_ff;
   logic [PW-1:0]  add_mag;
   logic           add_neg;

   // gcd
   logic [PW-1:0]  u_ff, u_in, v_ff, v_in;
   logic [KW-1:0]  k_ff, k_in;

   // divider
   logic [PW-1:0]  g_ff, rem_ff, quo_ff, qnum_ff;
   logic [PW:0]    rem_sh, rem_sub;
   logic           div_ge;

   // commit
   logic           ovf;
   logic [1:0]     status;
   logic [AW-1:0]  out_num;
   far_pkg::rsp_type rsp_ff;

   assign nraw = req_data.numerator;
   assign draw = req_data.denominator;
   assign nmag = nraw[IW-1] ? (~nraw + 1'b1) : nraw;
   assign dmag = draw[IW-1] ? (~draw + 1'b1) : draw;

   always_comb begin
      unique case (cmd.mul_sel)
         far_pkg::MUL_SEL_P1: begin
            mul_a = acc_mag_ff;
            mul_b = dmag_ff;
         end
         far_pkg::MUL_SEL_P2: begin
            mul_a = {1'b0, acc_den_ff};
            mul_b = nmag_ff;
         end
         far_pkg::MUL_SEL_DEN: begin
            mul_a = {1'b0, acc_den_ff};
            mul_b = dmag_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      priority if (acc_neg_ff == sneg_ff) begin
         add_mag = p1_ff + p2_ff;
         add_neg = sneg_ff;
      end else if (p1_ff >= p2_ff) begin
         add_mag = p1_ff - p2_ff;
         add_neg = acc_neg_ff;
      end else begin
         add_mag = p2_ff - p1_ff;
         add_neg = sneg_ff;
      end
   end

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      priority if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = (u_ff - v_ff) >> 1;
      end else begin
         v_in = (v_ff - u_ff) >> 1;
      end
   end

   assign stat.gcd_done = (u_ff == '0);
   assign stat.den_zero = dzero_ff;

   assign rem_sh  = {rem_ff, quo_ff[PW-1]};
   assign rem_sub = rem_sh - {1'b0, g_ff};
   assign div_ge  = (rem_sh >= {1'b0, g_ff});

   assign ovf = (quo_ff > POS_LIM) || (qnum_ff > (rneg_ff ? NEG_LIM : POS_LIM));

   always_comb begin
      priority if (dzero_ff) begin
         status = far_pkg::STATUS_ZERO_DEN;
      end else if (ovf) begin
         status = far_pkg::STATUS_OVERFLOW;
      end else begin
         status = far_pkg::STATUS_OK;
      end
   end

   always_comb begin
      acc_mag_in = acc_mag_ff;
      acc_neg_in = acc_neg_ff;
      acc_den_in = acc_den_ff;
      if (status == far_pkg::STATUS_OK) begin
         acc_mag_in = qnum_ff[AW-1:0];
         acc_neg_in = rneg_ff;
         acc_den_in = quo_ff[DW-1:0];
      end
   end

   assign out_num = acc_neg_in ? (~acc_mag_in + 1'b1) : acc_mag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_mag_ff <= '0;
         acc_neg_ff <= 1'b0;
         acc_den_ff <= DW'(1);
      end else if (cmd.accept && req_data.clear_first) begin
         acc_mag_ff <= '0;
         acc_neg_ff <= 1'b0;
         acc_den_ff <= DW'(1);
      end else if (cmd.commit) begin
         acc_mag_ff <= acc_mag_in;
         acc_neg_ff <= acc_neg_in;
         acc_den_ff <= acc_den_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         nmag_ff  <= nmag;
         dmag_ff  <= dmag;
         dzero_ff <= (dmag == '0);
         sneg_ff  <= (nraw[IW-1] != draw[IW-1]) && (nmag != '0);
      end
      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            far_pkg::MUL_SEL_P1:  p1_ff  <= mul_p;
            far_pkg::MUL_SEL_P2:  p2_ff  <= mul_p;
            far_pkg::MUL_SEL_DEN: den_ff <= mul_p;
            default: begin
            end
         endcase
      end
      if (cmd.add) begin
         mag_ff  <= add_mag;
         rneg_ff <= add_neg && (add_mag != '0);
         u_ff    <= add_mag;
         v_ff    <= den_ff;
         k_ff    <= '0;
      end else if (cmd.gcd_step) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
      if (cmd.scale) begin
         g_ff   <= v_ff << k_ff;
         quo_ff <= mag_ff;
         rem_ff <= '0;
      end else if (cmd.div_mid) begin
         qnum_ff <= quo_ff;
         quo_ff  <= den_ff;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
         quo_ff <= {quo_ff[PW-2:0], div_ge};
      end
      if (cmd.commit) begin
         rsp_ff.sum_numerator   <= out_num;
         rsp_ff.sum_denominator <= acc_den_in;
         rsp_ff.is_whole        <= (acc_mag_in == '0) || (acc_den_in == DW'(1));
         rsp_ff.status          <= status;
      end
   end

   assign rsp_data = rsp_ff;

   `FAR_ASSERT(a_den_nonzero, clock, reset, acc_den_ff != '0,
      "stored denominator is zero")
   `FAR_ASSERT_IMP(a_zero_positive, clock, reset, acc_mag_ff == '0, !acc_neg_ff,
      "zero sum carries a sign")
   `FAR_ASSERT_IMP(a_gcd_live, clock, reset, cmd.gcd_step, u_ff != '0,
      "gcd step issued after completion")

endmodule

`default_nettype wire

@@ rtl/fraction_accumulate_reduce.sv @@
// ---------------------------------------------------------------------------
// Fraction accumulate and reduce
// Running sum of signed fractions, kept in lowest terms via binary GCD.
// ---------------------------------------------------------------------------
// Sequence: a zero denominator goes from the first multiply state straight to
//   the response; otherwise the multiplies, the add, the binary GCD loop, the
//   scale and the shared 48-step restoring divider, run twice, precede it.
// One request is handled at a time (req_stall is high while not idle).
// A new request is taken while the previous response still waits.
// Reset (synchronous, active high) sets the sum to 0/1 and drops all requests.
`default_nettype none

module fraction_accumulate_reduce (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire far_pkg::req_type   req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      far_pkg::rsp_type   rsp_data
);

   far_pkg::cmd_type   cmd;
   far_pkg::stat_type  stat;

   far_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   far_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

`default_nettype wire
